// ----- src/efd_pkg.sv -----
// Shared constants and result word type for the escaped frame deframer.
package efd_pkg;

    localparam logic [7:0] START_BYTE = 8'h7D;
    localparam logic [7:0] STOP_BYTE  = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7F;

    localparam int POS_W = 6;
    localparam int LEN_W = 7;

    typedef struct packed {
        logic             stored;
        logic [7:0]       data_byte;
        logic [POS_W-1:0] position;
        logic             frame_end;
        logic             checksum_ok;
        logic [LEN_W-1:0] frame_length;
        logic             overflow;
    } t_result;

endpackage

// ----- src/efd_step.sv -----
// Per-byte deframing logic: next frame state and the result word for one byte.
module efd_step
    import efd_pkg::*;
#(
    parameter int BUFFER_BYTES = 64,
    parameter int CNT_W        = 7
) (
    input  logic [7:0]       i_rx_byte,
    input  logic [CNT_W-1:0] i_cnt,
    input  logic             i_esc,
    input  logic [7:0]       i_xor,
    input  logic             i_ovf,
    output logic [CNT_W-1:0] o_cnt,
    output logic             o_esc,
    output logic [7:0]       o_xor,
    output logic             o_ovf,
    output t_result          o_result
);

    logic             is_start;
    logic             is_esc;
    logic             full;
    logic [CNT_W-1:0] cnt_inc;
    logic [15:0]      cnt_ext;
    logic [15:0]      len_ext;
    logic             ovf_upd;
    logic             stop_hit;

    assign is_start = (i_cnt == '0) && (i_rx_byte == START_BYTE);
    assign is_esc   = !i_esc && (i_rx_byte == ESC_BYTE);
    assign full     = (i_cnt == CNT_W'(BUFFER_BYTES));
    assign cnt_inc  = full ? i_cnt : i_cnt + CNT_W'(1);
    assign ovf_upd  = i_ovf | full;
    assign stop_hit = !i_esc && (i_rx_byte == STOP_BYTE);
    assign cnt_ext  = 16'(i_cnt);

    // Pick the branch: frame start, escape marker, or ordinary byte
    always_comb begin
        o_cnt    = i_cnt;
        o_esc    = i_esc;
        o_xor    = i_xor;
        o_ovf    = i_ovf;
        o_result = '0;
        len_ext  = 16'(i_cnt);
        priority if (is_start) begin
            o_cnt                 = CNT_W'(1);
            o_esc                 = 1'b0;
            o_xor                 = START_BYTE;
            o_ovf                 = 1'b0;
            o_result.stored       = 1'b1;
            o_result.data_byte    = i_rx_byte;
            len_ext               = 16'(1);
        end else if (is_esc) begin
            // Drop the escape and mark the next byte literal
            o_esc = 1'b1;
        end else begin
            o_esc                 = 1'b0;
            o_cnt                 = cnt_inc;
            o_ovf                 = ovf_upd;
            o_result.stored       = !full;
            o_result.data_byte    = full ? 8'h00 : i_rx_byte;
            o_result.position     = full ? '0 : cnt_ext[POS_W-1:0];
            len_ext               = 16'(cnt_inc);
            if (stop_hit) begin
                o_result.frame_end   = 1'b1;
                o_result.checksum_ok = (i_xor == 8'h00) && (cnt_inc >= CNT_W'(3)) && !ovf_upd;
            end else if (!full) begin
                o_xor = i_xor ^ i_rx_byte;
            end
        end
        o_result.frame_length = len_ext[LEN_W-1:0];
        o_result.overflow     = o_ovf;
        // Return to an empty frame after the stop byte
        if (o_result.frame_end) begin
            o_cnt = '0;
            o_esc = 1'b0;
            o_xor = 8'h00;
            o_ovf = 1'b0;
        end
    end

endmodule

// ----- src/efd_out_reg.sv -----
// Output register stage holding one result word until the sink takes it.
module efd_out_reg
    import efd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_take,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_take;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Track occupancy of the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Capture a new word
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- src/escaped_frame_deframer_core.sv -----
// Top level of the escaped frame deframer: frame state registers and output stage.
// The result word of an accepted byte is registered and shows in the next cycle.
// Takes one byte per cycle while the output stage is free (o_ready high).
// o_ready stays high while the output stage is empty or being drained.
// Reset (synchronous, active low) empties the output stage and clears the
// byte count, escape flag, running XOR and overflow flag.
module escaped_frame_deframer_core
    import efd_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_rx_byte,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_stored,
    output logic [7:0]          o_data_byte,
    output logic [POS_W-1:0]    o_position,
    output logic                o_frame_end,
    output logic                o_checksum_ok,
    output logic [LEN_W-1:0]    o_frame_length,
    output logic                o_overflow
);

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_esc, n_esc;
    logic [7:0]       r_xor, n_xor;
    logic             r_ovf, n_ovf;
    t_result          step_result;
    t_result          out_result;
    logic             accept;
    logic             out_free;

    assign o_ready = out_free;
    assign accept  = i_valid && out_free;

    efd_step #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .CNT_W       (CNT_W)
    ) u_step (
        .i_rx_byte(i_rx_byte),
        .i_cnt    (r_cnt),
        .i_esc    (r_esc),
        .i_xor    (r_xor),
        .i_ovf    (r_ovf),
        .o_cnt    (n_cnt),
        .o_esc    (n_esc),
        .o_xor    (n_xor),
        .o_ovf    (n_ovf),
        .o_result (step_result)
    );

    // Advance frame state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_esc <= 1'b0;
            r_xor <= 8'h00;
            r_ovf <= 1'b0;
        end else if (accept) begin
            r_cnt <= n_cnt;
            r_esc <= n_esc;
            r_xor <= n_xor;
            r_ovf <= n_ovf;
        end
    end

    efd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_result(step_result),
        .i_take  (i_ready),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_result(out_result)
    );

    assign o_stored       = out_result.stored;
    assign o_data_byte    = out_result.data_byte;
    assign o_position     = out_result.position;
    assign o_frame_end    = out_result.frame_end;
    assign o_checksum_ok  = out_result.checksum_ok;
    assign o_frame_length = out_result.frame_length;
    assign o_overflow     = out_result.overflow;

endmodule

// ----- src/efd_checker.sv -----
// Port-level checks for the escaped frame deframer, bound to the top level.
module efd_checker
    import efd_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic [7:0]       i_rx_byte,
    input logic             o_valid,
    input logic             i_ready,
    input logic             o_stored,
    input logic [7:0]       o_data_byte,
    input logic [POS_W-1:0] o_position,
    input logic             o_frame_end,
    input logic             o_checksum_ok,
    input logic [LEN_W-1:0] o_frame_length,
    input logic             o_overflow
);

    // Hold a waiting input word until it is accepted
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_rx_byte))
        else $error("waiting input word changed");

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data_byte) && $stable(o_frame_end)
            && $stable(o_frame_length))
        else $error("stalled result word changed");

    // Every accepted byte yields a result word in the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("accepted byte produced no result word");

    // A dropped byte reports zero data and position
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_stored |-> o_data_byte == 8'h00 && o_position == '0)
        else $error("unstored word carries data");

    // Check result only at the frame end
    a_ok_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_checksum_ok |-> o_frame_end && !o_overflow
            && (o_frame_length >= LEN_W'(3) || o_frame_length == '0))
        else $error("checksum_ok outside a valid frame end");

endmodule

bind escaped_frame_deframer_core efd_checker u_efd_checker (.*);

// ----- bench/tb_top.sv -----
// Self-checking bench for the escaped frame deframer: directed byte table, then random frames.
module tb_top;
    import efd_pkg::*;

    localparam int BUFFER_BYTES = 64;
    localparam int DIRECTED_COUNT = 26;
    localparam int RANDOM_PER_PHASE = 232;
    localparam int NUM_PHASES = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_result    want;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [7:0]          i_rx_byte = 8'h00;
    logic                i_ready = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic                o_stored;
    logic [7:0]          o_data_byte;
    logic [POS_W-1:0]    o_position;
    logic                o_frame_end;
    logic                o_checksum_ok;
    logic [LEN_W-1:0]    o_frame_length;
    logic                o_overflow;

    // Frame state mirrored by the predictor
    int                  frm_count = 0;
    logic                esc_pending = 1'b0;
    logic [7:0]          frm_xor = 8'h00;
    logic                frm_ovf = 1'b0;

    t_result             expected_words[$];
    int                  mismatch_count = 0;
    int                  bytes_sent = 0;
    int                  frames_sent = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int unsigned         cycle_count = 0;

    int                  phase_send_pct [NUM_PHASES] = '{0, 49, 0, 26};
    int                  phase_recv_pct [NUM_PHASES] = '{0, 0, 49, 26};

    // Result word fields: stored, data, position, end, ok, length, overflow
    t_stim_row directed_rows [DIRECTED_COUNT] = '{
        // start byte, escaped stop as data, good checksum
        '{8'h7D, 1'b1, '{1'b1, 8'h7D, 6'd0, 1'b0, 1'b0, 7'd1, 1'b0}},
        '{8'h7F, 1'b1, '{1'b0, 8'h00, 6'd0, 1'b0, 1'b0, 7'd1, 1'b0}},
        '{8'h7E, 1'b1, '{1'b1, 8'h7E, 6'd1, 1'b0, 1'b0, 7'd2, 1'b0}},
        '{8'h00, 1'b0, '0},
        '{8'h03, 1'b0, '0},
        '{8'h7E, 1'b1, '{1'b1, 8'h7E, 6'd4, 1'b1, 1'b1, 7'd5, 1'b0}},
        // short frames fail the check, even with a zero XOR
        '{8'h7D, 1'b1, '{1'b1, 8'h7D, 6'd0, 1'b0, 1'b0, 7'd1, 1'b0}},
        '{8'h7E, 1'b1, '{1'b1, 8'h7E, 6'd1, 1'b1, 1'b0, 7'd2, 1'b0}},
        '{8'h00, 1'b1, '{1'b1, 8'h00, 6'd0, 1'b0, 1'b0, 7'd1, 1'b0}},
        '{8'h7E, 1'b1, '{1'b1, 8'h7E, 6'd1, 1'b1, 1'b0, 7'd2, 1'b0}},
        // no start byte, start value inside the frame is data
        '{8'hFF, 1'b1, '{1'b1, 8'hFF, 6'd0, 1'b0, 1'b0, 7'd1, 1'b0}},
        '{8'h7D, 1'b1, '{1'b1, 8'h7D, 6'd1, 1'b0, 1'b0, 7'd2, 1'b0}},
        '{8'h82, 1'b0, '0},
        '{8'h7E, 1'b1, '{1'b1, 8'h7E, 6'd3, 1'b1, 1'b1, 7'd4, 1'b0}},
        // escaped escape stored as data
        '{8'h7F, 1'b1, '{1'b0, 8'h00, 6'd0, 1'b0, 1'b0, 7'd0, 1'b0}},
        '{8'h7F, 1'b1, '{1'b1, 8'h7F, 6'd0, 1'b0, 1'b0, 7'd1, 1'b0}},
        '{8'h7F, 1'b1, '{1'b0, 8'h00, 6'd0, 1'b0, 1'b0, 7'd1, 1'b0}},
        '{8'h7F, 1'b1, '{1'b1, 8'h7F, 6'd1, 1'b0, 1'b0, 7'd2, 1'b0}},
        '{8'h00, 1'b0, '0},
        '{8'h7E, 1'b1, '{1'b1, 8'h7E, 6'd3, 1'b1, 1'b1, 7'd4, 1'b0}},
        // start byte cancels a pending escape, so the stop still ends the frame
        '{8'h7F, 1'b1, '{1'b0, 8'h00, 6'd0, 1'b0, 1'b0, 7'd0, 1'b0}},
        '{8'h7D, 1'b1, '{1'b1, 8'h7D, 6'd0, 1'b0, 1'b0, 7'd1, 1'b0}},
        '{8'h7E, 1'b1, '{1'b1, 8'h7E, 6'd1, 1'b1, 1'b0, 7'd2, 1'b0}},
        // bad checksum
        '{8'h11, 1'b1, '{1'b1, 8'h11, 6'd0, 1'b0, 1'b0, 7'd1, 1'b0}},
        '{8'h22, 1'b0, '0},
        '{8'h7E, 1'b1, '{1'b1, 8'h7E, 6'd2, 1'b1, 1'b0, 7'd3, 1'b0}}
    };

    escaped_frame_deframer_core #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_stored       (o_stored),
        .o_data_byte    (o_data_byte),
        .o_position     (o_position),
        .o_frame_end    (o_frame_end),
        .o_checksum_ok  (o_checksum_ok),
        .o_frame_length (o_frame_length),
        .o_overflow     (o_overflow)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Advance the frame state by one received byte and return its result word
    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result r;
        logic    literal;
        r = '0;
        if (frm_count == 0 && b == START_BYTE) begin
            esc_pending = 1'b0;
            frm_ovf = 1'b0;
            frm_xor = START_BYTE;
            r.stored = 1'b1;
            r.data_byte = b;
            frm_count = 1;
        end else if (!esc_pending && b == ESC_BYTE) begin
            esc_pending = 1'b1;
        end else begin
            literal = esc_pending;
            esc_pending = 1'b0;
            // drop the byte once the buffer is full
            if (frm_count >= BUFFER_BYTES) begin
                frm_ovf = 1'b1;
            end else begin
                r.stored = 1'b1;
                r.data_byte = b;
                r.position = POS_W'(frm_count);
                frm_count = frm_count + 1;
            end
            if (!literal && b == STOP_BYTE) begin
                r.frame_end = 1'b1;
                r.checksum_ok = (frm_xor == 8'h00 && frm_count >= 3 && !frm_ovf);
            end else if (r.stored) begin
                frm_xor = frm_xor ^ b;
            end
        end
        r.frame_length = LEN_W'(frm_count);
        r.overflow = frm_ovf;
        if (r.frame_end) begin
            frm_count = 0;
            esc_pending = 1'b0;
            frm_xor = 8'h00;
            frm_ovf = 1'b0;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // Check each result word at the falling edge in the cycle in which it is taken; all signals are settled here
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word expected none actual data %0h pos %0d",
                         $time, o_data_byte, o_position);
            end else begin
                want = expected_words.pop_front();
                check_field("stored", want.stored, o_stored);
                check_field("data_byte", want.data_byte, o_data_byte);
                check_field("position", want.position, o_position);
                check_field("frame_end", want.frame_end, o_frame_end);
                check_field("checksum_ok", want.checksum_ok, o_checksum_ok);
                check_field("frame_length", want.frame_length, o_frame_length);
                check_field("overflow", want.overflow, o_overflow);
            end
        end
    end

    // Present one byte, hold it until taken, then record its result word
    task automatic send_byte(input logic [7:0] b, input logic use_typed,
                             input t_result typed_word);
        int      gap;
        t_result predicted;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        predicted = deframe_byte(b);
        expected_words.push_back(use_typed ? typed_word : predicted);
        bytes_sent++;
    endtask

    // Favor the framing codes and the value extremes
    function automatic logic [7:0] pick_byte();
        logic [7:0] specials [5] = '{START_BYTE, STOP_BYTE, ESC_BYTE, 8'h00, 8'hFF};
        if ($urandom_range(99) < 30) return specials[$urandom_range(4)];
        return 8'($urandom_range(255));
    endfunction

    // Escape the stop and escape codes inside the frame body
    task automatic send_body_byte(input logic [7:0] b);
        if (b == STOP_BYTE || b == ESC_BYTE) send_byte(ESC_BYTE, 1'b0, '0);
        send_byte(b, 1'b0, '0);
    endtask

    // Send one frame: mostly well formed, some with bad or missing checksum,
    // every twelfth one (if not noise) long, often enough to run past the buffer, a few pure noise
    task automatic send_frame();
        int         body_len;
        int         n;
        logic [7:0] acc;
        logic [7:0] b;
        frames_sent++;
        if ($urandom_range(99) < 10) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) send_byte(pick_byte(), 1'b0, '0);
        end else begin
            body_len = (frames_sent % 12 == 1) ? $urandom_range(58, 70) : $urandom_range(0, 10);
            acc = 8'h00;
            if ($urandom_range(99) < 80) begin
                send_byte(START_BYTE, 1'b0, '0);
                acc = START_BYTE;
            end
            for (int i = 0; i < body_len; i++) begin
                b = pick_byte();
                acc = acc ^ b;
                send_body_byte(b);
            end
            if ($urandom_range(99) < 15) acc = acc ^ (8'h01 << $urandom_range(7));
            if ($urandom_range(99) < 92) send_body_byte(acc);
            send_byte(STOP_BYTE, 1'b0, '0);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table with no idling
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random frames under each idling pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = phase_send_pct[p];
            recv_stall_pct = phase_recv_pct[p];
            while (bytes_sent < DIRECTED_COUNT + (p + 1) * RANDOM_PER_PHASE) send_frame();
        end

        i_valid <= 1'b0;
        recv_stall_pct = 0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
